// ===== sv/swf_pkg.sv =====
// ----------------------------------------------------------------------------
// swf_pkg - square waypoint follower shared definitions
// Register indexes, reset values and corner codes for the follower.
// ----------------------------------------------------------------------------
`default_nettype none

package swf_pkg;

  // configuration register index
  localparam int CFG_IDX_W = 3;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_SIDE_LENGTH   = 3'd0;
  localparam cfg_idx_t CFG_SIDE_WIDTH    = 3'd1;
  localparam cfg_idx_t CFG_ALTITUDE      = 3'd2;
  localparam cfg_idx_t CFG_ORIGIN_X      = 3'd3;
  localparam cfg_idx_t CFG_ORIGIN_Y      = 3'd4;
  localparam cfg_idx_t CFG_POS_TOLERANCE = 3'd5;
  localparam cfg_idx_t CFG_SPEED_LIMIT   = 3'd6;

  // field widths fixed by the Q8.8 format
  localparam int COORD_W = 16;
  localparam int LIMIT_W = 15;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [LIMIT_W-1:0]        limit_t;

  // corner index codes, walked in order round the square
  typedef logic [1:0] corner_t;

  localparam corner_t CORNER_ZERO  = 2'd0;
  localparam corner_t CORNER_ONE   = 2'd1;
  localparam corner_t CORNER_TWO   = 2'd2;
  localparam corner_t CORNER_THREE = 2'd3;

  // register reset values
  localparam coord_t RST_SIDE_LENGTH   = 16'sd512;
  localparam coord_t RST_SIDE_WIDTH    = 16'sd512;
  localparam coord_t RST_ALTITUDE      = -16'sd768;
  localparam coord_t RST_ORIGIN_X      = 16'sd512;
  localparam coord_t RST_ORIGIN_Y      = 16'sd512;
  localparam limit_t RST_POS_TOLERANCE = 15'd128;
  localparam limit_t RST_SPEED_LIMIT   = 15'd512;

endpackage

`default_nettype wire

// ===== sv/square_waypoint_follower.sv =====
// ----------------------------------------------------------------------------
// square_waypoint_follower - proportional follower round a square of corners
// Takes one measured x/y/z position per transaction and returns one velocity
// command per transaction: target corner minus position with unit gain,
// clamped per axis to +/- speed_limit, with a reached flag that steps the
// corner index round the four corners when every axis is inside tolerance.
// One transaction is accepted every clock cycle while in_stall is low. The
// transaction waits in the input register until the result register is free
// and is then held in the result register until it is taken. The corner
// index is read and updated as a transaction passes between the registers,
// so consecutive transactions follow each other with no gap. The
// input register takes a new transaction while a result is held by a stalled
// output only when the input register is empty. Corner sums and errors
// saturate to the signed POS_WIDTH range. Configuration writes are always
// accepted and are meant to happen only while no transaction is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module square_waypoint_follower #(
  parameter int POS_WIDTH = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,

  // position channel
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic signed [15:0]    in_meas_x,
  input  wire logic signed [15:0]    in_meas_y,
  input  wire logic signed [15:0]    in_meas_z,

  // command channel
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic signed [15:0]         out_vel_x,
  output logic signed [15:0]         out_vel_y,
  output logic signed [15:0]         out_vel_z,
  output logic [1:0]                 out_corner_used,
  output logic                       out_reached,

  // configuration write channel
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire swf_pkg::cfg_idx_t     cfg_index,
  input  wire logic [15:0]           cfg_data
);

  // working width: room for a corner sum, an error and its magnitude
  localparam int SW = ((POS_WIDTH > 17) ? POS_WIDTH : 17) + 2;

  localparam logic signed [SW-1:0] SAT_HI = SW'((64'sd1 <<< (POS_WIDTH - 1)) - 64'sd1);
  localparam logic signed [SW-1:0] SAT_LO = SW'(-(64'sd1 <<< (POS_WIDTH - 1)));

  function automatic logic signed [SW-1:0] sat_pos(input logic signed [SW-1:0] v);
    logic signed [SW-1:0] r;
    if (v > SAT_HI) begin
      r = SAT_HI;
    end else if (v < SAT_LO) begin
      r = SAT_LO;
    end else begin
      r = v;
    end
    return r;
  endfunction

  // configuration registers
  swf_pkg::coord_t side_length_r;
  swf_pkg::coord_t side_width_r;
  swf_pkg::coord_t altitude_r;
  swf_pkg::coord_t origin_x_r;
  swf_pkg::coord_t origin_y_r;
  swf_pkg::limit_t pos_tolerance_r;
  swf_pkg::limit_t speed_limit_r;

  swf_pkg::corner_t corner_r;
  swf_pkg::corner_t corner_nxt;

  // input stage
  logic            s1_valid_r;
  swf_pkg::coord_t s1_meas_r [3];

  // result stage
  logic                 out_valid_r;
  logic signed [15:0]   out_vel_r [3];
  swf_pkg::corner_t     out_corner_r;
  logic                 out_reached_r;

  logic                 out_free;
  logic                 s1_fire;

  logic signed [SW-1:0] tgt   [3];
  logic signed [SW-1:0] err   [3];
  logic signed [SW-1:0] mag   [3];
  logic signed [SW-1:0] vel   [3];
  logic signed [SW-1:0] lim_e;
  logic signed [SW-1:0] tol_e;
  logic                 all_in;

  assign cfg_ready = 1'b1;

  // configuration write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_length_r   <= swf_pkg::RST_SIDE_LENGTH;
      side_width_r    <= swf_pkg::RST_SIDE_WIDTH;
      altitude_r      <= swf_pkg::RST_ALTITUDE;
      origin_x_r      <= swf_pkg::RST_ORIGIN_X;
      origin_y_r      <= swf_pkg::RST_ORIGIN_Y;
      pos_tolerance_r <= swf_pkg::RST_POS_TOLERANCE;
      speed_limit_r   <= swf_pkg::RST_SPEED_LIMIT;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        swf_pkg::CFG_SIDE_LENGTH:   side_length_r   <= cfg_data;
        swf_pkg::CFG_SIDE_WIDTH:    side_width_r    <= cfg_data;
        swf_pkg::CFG_ALTITUDE:      altitude_r      <= cfg_data;
        swf_pkg::CFG_ORIGIN_X:      origin_x_r      <= cfg_data;
        swf_pkg::CFG_ORIGIN_Y:      origin_y_r      <= cfg_data;
        swf_pkg::CFG_POS_TOLERANCE: pos_tolerance_r <= cfg_data[swf_pkg::LIMIT_W-1:0];
        swf_pkg::CFG_SPEED_LIMIT:   speed_limit_r   <= cfg_data[swf_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline flow control
  assign out_free = !out_valid_r || !out_stall;
  assign s1_fire  = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_meas_r[0] <= in_meas_x;
      s1_meas_r[1] <= in_meas_y;
      s1_meas_r[2] <= in_meas_z;
    end
  end

  // corner targets, errors, clamp and reach test
  always_comb begin
    lim_e = $signed({{(SW-swf_pkg::LIMIT_W){1'b0}}, speed_limit_r});
    tol_e = $signed({{(SW-swf_pkg::LIMIT_W){1'b0}}, pos_tolerance_r});

    if (corner_r inside {swf_pkg::CORNER_ONE, swf_pkg::CORNER_TWO}) begin
      tgt[0] = sat_pos(SW'(origin_x_r) + SW'(side_length_r));
    end else begin
      tgt[0] = sat_pos(SW'(origin_x_r));
    end
    if (corner_r inside {swf_pkg::CORNER_TWO, swf_pkg::CORNER_THREE}) begin
      tgt[1] = sat_pos(SW'(origin_y_r) + SW'(side_width_r));
    end else begin
      tgt[1] = sat_pos(SW'(origin_y_r));
    end
    tgt[2] = sat_pos(SW'(altitude_r));

    all_in = 1'b1;
    for (int i = 0; i < 3; i++) begin
      err[i] = sat_pos(tgt[i] - SW'(s1_meas_r[i]));
      mag[i] = (err[i] < 0) ? -err[i] : err[i];
      if (err[i] > lim_e) begin
        vel[i] = lim_e;
      end else if (err[i] < -lim_e) begin
        vel[i] = -lim_e;
      end else begin
        vel[i] = err[i];
      end
      if (!(mag[i] < tol_e)) begin
        all_in = 1'b0;
      end
    end

    corner_nxt = corner_r;
    if (s1_fire && all_in) begin
      corner_nxt = corner_r + 2'd1;
    end
  end

  // corner index
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      corner_r <= swf_pkg::CORNER_ZERO;
    end else begin
      corner_r <= corner_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      for (int i = 0; i < 3; i++) begin
        out_vel_r[i] <= vel[i][15:0];
      end
      out_corner_r  <= corner_r;
      out_reached_r <= all_in;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_vel_x       = out_vel_r[0];
  assign out_vel_y       = out_vel_r[1];
  assign out_vel_z       = out_vel_r[2];
  assign out_corner_used = out_corner_r;
  assign out_reached     = out_reached_r;

endmodule

`default_nettype wire
